>>> rtl/core/wse_pkg.sv
// shared types, constants and helpers for the ws2812 spi frame encoder
// no dependencies
package wse_pkg;

  // default frame limits, in bytes
  localparam int DEF_BUFFER_BYTES = 512;
  localparam int DEF_PAD_BYTES    = 256;

  // most words one frame may carry
  localparam int MAX_WORDS = 64;
  localparam int WCNT_W    = $clog2(MAX_WORDS + 1);

  // spi byte codes for one led bit
  localparam logic [7:0] CODE_ONE  = 8'hF0;
  localparam logic [7:0] CODE_ZERO = 8'hC0;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // one classified show request
  typedef struct packed {
    logic              err;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [WCNT_W-1:0] payload_words;
    logic [WCNT_W-1:0] total;
  } cmd_t;

  // one color byte to eight spi bytes, msb first in the top byte
  function automatic logic [63:0] expand_byte(input logic [7:0] level);
    logic [63:0] word;
    word = '0;
    for (int i = 0; i < 8; i++) begin
      word[8*i +: 8] = level[i] ? CODE_ONE : CODE_ZERO;
    end
    return word;
  endfunction

endpackage

>>> rtl/core/wse_front.sv
// front end: checks a show request and works out its frame length
// depends on wse_pkg
module wse_front import wse_pkg::*; #(
  parameter int BUFFER_BYTES = DEF_BUFFER_BYTES,
  parameter int PAD_BYTES    = DEF_PAD_BYTES
) (
  input  logic [7:0] red_level,
  input  logic [7:0] green_level,
  input  logic [7:0] blue_level,
  input  logic [7:0] pixel_count,
  output cmd_t       cmd
);

  localparam int                PAD_RAW   = (PAD_BYTES + 7) / 8;
  localparam int                PAD_CAP   = (PAD_RAW > MAX_WORDS) ? MAX_WORDS : PAD_RAW;
  localparam logic [WCNT_W-1:0] PAD_WORDS = WCNT_W'(PAD_CAP);
  localparam logic [12:0]       BUF_LIM   = 13'(BUFFER_BYTES);
  localparam logic [9:0]        WORD_LIM  = 10'(MAX_WORDS);

  logic [12:0]       payload_bytes;
  logic [9:0]        payload_words;
  logic [WCNT_W-1:0] words_short;
  logic              err;

  // count * 24 and count * 3 by shift and add
  assign payload_bytes = {1'b0, pixel_count, 4'b0} + {2'b0, pixel_count, 3'b0};
  assign payload_words = {2'b0, pixel_count} + {1'b0, pixel_count, 1'b0};
  assign words_short   = payload_words[WCNT_W-1:0];

  assign err = (pixel_count == 8'd0) || (payload_bytes > BUF_LIM) ||
               (payload_words > WORD_LIM);

  always_comb begin
    cmd.err   = err;
    cmd.red   = red_level;
    cmd.green = green_level;
    cmd.blue  = blue_level;
    if (err) begin
      cmd.payload_words = '0;
      cmd.total         = WCNT_W'(1);
    end else begin
      cmd.payload_words = words_short;
      cmd.total         = (words_short > PAD_WORDS) ? words_short : PAD_WORDS;
    end
  end

endmodule

>>> rtl/core/wse_queue.sv
// short command queue between the front and back ends
// depends on wse_pkg
module wse_queue import wse_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output cmd_t pop_data
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  localparam logic [QPTR_W-1:0] LAST_SLOT = QPTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QCNT_W-1:0] FULL_CNT  = QCNT_W'(QUEUE_DEPTH);

  assign full      = (count == FULL_CNT);
  assign not_empty = (count != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/core/wse_back.sv
// back end: walks one frame word by word into the output register
// depends on wse_pkg
module wse_back import wse_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  cmd_t        q_data,
  output logic        q_pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,
  output logic        m_tuser,
  output logic        m_tlast
);

  localparam logic [1:0] PH_GREEN = 2'd0;
  localparam logic [1:0] PH_RED   = 2'd1;
  localparam logic [1:0] PH_BLUE  = 2'd2;

  cmd_t              cur;
  logic              busy;
  logic [WCNT_W-1:0] k;
  logic [1:0]        phase;
  logic              emit;
  logic              emit_last;
  logic [7:0]        level;
  logic [63:0]       word;

  assign emit      = busy && (!m_tvalid || m_tready);
  assign emit_last = emit && (k == cur.total - WCNT_W'(1));
  assign q_pop     = q_valid && (!busy || emit_last);

  always_comb begin
    case (phase)
      PH_GREEN: level = cur.green;
      PH_RED:   level = cur.red;
      PH_BLUE:  level = cur.blue;
      default:  level = cur.green;
    endcase
    word = (k < cur.payload_words) ? expand_byte(level) : 64'd0;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
    if (emit) begin
      m_tdata <= word;
      m_tuser <= cur.err;
      m_tlast <= (k == cur.total - WCNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      k        <= '0;
      phase    <= PH_GREEN;
      m_tvalid <= 1'b0;
    end else begin
      if (q_pop) begin
        busy  <= 1'b1;
        k     <= '0;
        phase <= PH_GREEN;
      end else if (emit_last) begin
        busy <= 1'b0;
      end else if (emit) begin
        k     <= k + WCNT_W'(1);
        phase <= (phase == PH_BLUE) ? PH_GREEN : phase + 2'd1;
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/core/ws2812_spi_frame_encoder_core.sv
// top level of the ws2812 spi frame encoder
// depends on wse_pkg, wse_front, wse_queue and wse_back
//
// usage:
//  - the slave channel takes one show request per item: one red, green and
//    blue level used for every pixel and a pixel count
//  - the master channel returns the frame as 64-bit words, one color byte
//    expanded to eight spi bytes per word, pixels in green, red, blue order,
//    then zero words up to the pad length; tlast marks the final word
//  - a pixel count of zero or a payload over the buffer or the word limit
//    gives one word of zero with tuser set and tlast set
// timing:
//  - when the queue is empty, a request passes the queue slot and the back
//    end's command register before its first word shows on the master side
//  - a frame is max(3 * pixel_count, pad words) words long, one word for an
//    error; the back end's word counter emits one word per cycle unless stalled
//  - a two entry command queue lets the slave side accept up to two more
//    requests while a frame is being sent
// reset and stall:
//  - rst clears the queue, the word counter and the output valid
//  - while tready is low the output word holds and the word counter waits;
//    the slave side stalls once the queue is full
module ws2812_spi_frame_encoder_core import wse_pkg::*; #(
  parameter int BUFFER_BYTES = DEF_BUFFER_BYTES,
  parameter int PAD_BYTES    = DEF_PAD_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // red_level, green_level, blue_level, pixel_count
  // word channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // spi_word
  output logic        m_tuser,   // status
  output logic        m_tlast    // last_word
);

  cmd_t front_cmd;
  cmd_t q_data;
  logic q_full;
  logic q_valid;
  logic q_pop;
  logic push;

  // request is classified combinationally and lands in the queue
  wse_front #(
    .BUFFER_BYTES(BUFFER_BYTES),
    .PAD_BYTES   (PAD_BYTES)
  ) u_front (
    .red_level  (s_tdata[7:0]),
    .green_level(s_tdata[15:8]),
    .blue_level (s_tdata[23:16]),
    .pixel_count(s_tdata[31:24]),
    .cmd        (front_cmd)
  );

  assign s_tready = !q_full;
  assign push     = s_tvalid && s_tready;

  wse_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(front_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_valid),
    .pop_data (q_data)
  );

  // back end runs one frame at a time into the output register
  wse_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

endmodule

>>> rtl/core/wse_checker.sv
// port level checks for the ws2812 spi frame encoder
// depends on ws2812_spi_frame_encoder_core, bound below
module wse_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [31:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // an error word is a lone zero word
  a_err_word: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast && (m_tdata == 64'd0))
    else $error("error word not a lone zero word");

  // ok words are zero padding or spi codes in the top and bottom byte positions
  a_codes: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser && (m_tdata != 64'd0) |->
      ((m_tdata[63:56] == 8'hF0) || (m_tdata[63:56] == 8'hC0)) &&
      ((m_tdata[7:0] == 8'hF0) || (m_tdata[7:0] == 8'hC0)))
    else $error("bad spi code in word");

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) &&
      $stable(m_tuser))
    else $error("output word changed under stall");

  // a waiting request holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
    else $error("request changed while waiting");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind ws2812_spi_frame_encoder_core wse_checker u_wse_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tdata (s_tdata),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser),
  .m_tlast (m_tlast)
);
